// ===== rtl/slfr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// slfr_pkg
// Shared types and constants for the serial line frame receiver: buffer
// geometry, operation codes, line control characters and item structs.
// ---------------------------------------------------------------------------
package slfr_pkg;

    // frame buffer geometry
    localparam int BUFFER_DEPTH = 128;
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int COUNT_W      = 8;
    localparam int DATA_W       = 8;
    localparam int INDEX_W      = 7;

    localparam logic [COUNT_W-1:0] DEPTH_LIMIT = COUNT_W'(BUFFER_DEPTH);

    // line control characters
    localparam logic [DATA_W-1:0] ASCII_CR = 8'h0D;
    localparam logic [DATA_W-1:0] ASCII_LF = 8'h0A;

    // result queue geometry
    localparam int RES_FIFO_DEPTH = 3;
    localparam int RES_PTR_W      = 2;
    localparam int RES_CNT_W      = 2;

    // item operation codes
    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_READ    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_STATUS  = 2'd3
    } op_t;

    // frame status after one item
    typedef struct packed {
        logic               frame_complete;
        logic               cr_pending;
        logic [COUNT_W-1:0] byte_count;
        logic [COUNT_W-1:0] expected_length;
        logic               frame_error;
        logic               byte_dropped;
    } status_t;

    // buffer write request from the framing logic
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } buf_wr_t;

    // one result item as held in the result queue
    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] read_data;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/slfr_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// slfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module slfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/slfr_frame.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// slfr_frame
// Framing state for one accepted item: CR-LF line framing or length-prefixed
// download framing, the buffer write it causes and the resulting status.
// ---------------------------------------------------------------------------
module slfr_frame
    import slfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [1:0]        op,
    input  wire logic [DATA_W-1:0] rx_byte,
    input  wire logic              download_mode,
    output status_t                status,
    output buf_wr_t                buf_wr
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               cr_seen_reg, cr_seen_next;
    logic               done_reg, done_next;
    logic [COUNT_W-1:0] announced_reg, announced_next;
    logic [COUNT_W-1:0] count_inc;
    logic               frame_error;
    logic               byte_dropped;

    assign count_inc = count_reg + COUNT_W'(1);

    // next frame state for the item
    always_comb
    begin
        count_next     = count_reg;
        cr_seen_next   = cr_seen_reg;
        done_next      = done_reg;
        announced_next = announced_reg;
        frame_error    = 1'b0;
        byte_dropped   = 1'b0;
        buf_wr.we      = 1'b0;
        buf_wr.addr    = ADDR_W'(count_reg);
        buf_wr.data    = rx_byte;
        if (step)
        begin
            unique case (op_t'(op)) inside
                OP_RX_BYTE:
                begin
                    if (done_reg)
                    begin
                        byte_dropped = 1'b1;
                    end
                    else if (!download_mode)
                    begin
                        // line framing
                        if (cr_seen_reg)
                        begin
                            if (rx_byte == ASCII_LF)
                            begin
                                done_next    = 1'b1;
                                cr_seen_next = 1'b0;
                            end
                            else
                            begin
                                count_next   = '0;
                                cr_seen_next = 1'b0;
                                frame_error  = 1'b1;
                            end
                        end
                        else if (count_reg < DEPTH_LIMIT)
                        begin
                            if (rx_byte == ASCII_CR)
                            begin
                                cr_seen_next = 1'b1;
                            end
                            else
                            begin
                                buf_wr.we  = 1'b1;
                                count_next = count_inc;
                            end
                        end
                        else
                        begin
                            // buffer full: discard
                            count_next   = '0;
                            cr_seen_next = 1'b0;
                            frame_error  = 1'b1;
                        end
                    end
                    else
                    begin
                        // download framing
                        if (announced_reg == '0)
                        begin
                            announced_next = rx_byte;
                        end
                        else
                        begin
                            buf_wr.we  = (count_reg < DEPTH_LIMIT);
                            count_next = count_inc;
                            if (count_inc == announced_reg)
                            begin
                                done_next = 1'b1;
                            end
                        end
                    end
                end
                OP_RELEASE:
                begin
                    count_next     = '0;
                    cr_seen_next   = 1'b0;
                    done_next      = 1'b0;
                    announced_next = '0;
                end
                OP_READ, OP_STATUS:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // status after the item
    always_comb
    begin
        status.frame_complete  = done_next;
        status.cr_pending      = cr_seen_next;
        status.byte_count      = count_next;
        status.expected_length = announced_next;
        status.frame_error     = frame_error;
        status.byte_dropped    = byte_dropped;
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cr_seen_reg   <= 1'b0;
            done_reg      <= 1'b0;
            announced_reg <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            cr_seen_reg   <= cr_seen_next;
            done_reg      <= done_next;
            announced_reg <= announced_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/serial_line_frame_receiver.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// serial_line_frame_receiver
// Collects received serial bytes into a frame buffer with line or download
// framing, and serves buffer reads and frame release.
// ---------------------------------------------------------------------------
// Takes one item per clock cycle while in_stall is low. Each accepted item
// updates the frame state and writes or reads the 128-byte frame buffer at
// the accepting edge; its result passes the result stage register and then
// the three-entry result queue. in_stall rises only when the queue, with the
// item still at work, is full, so with out_stall low the block runs at full
// rate. The frame buffer is not cleared by reset: only entries written by
// received bytes may be read back. The user must write download_mode through
// cfg_we/cfg_data only while no item is in flight; it is not enforced.
module serial_line_frame_receiver
    import slfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         op,
    input  wire logic [DATA_W-1:0]  rx_byte,
    input  wire logic [INDEX_W-1:0] read_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    frame_complete,
    output logic                    cr_pending,
    output logic [COUNT_W-1:0]      byte_count,
    output logic [COUNT_W-1:0]      expected_length,
    output logic                    frame_error,
    output logic                    byte_dropped,
    output logic [DATA_W-1:0]       read_data
);

    logic                 download_mode_reg;
    logic                 accept;
    logic                 rd_en;
    status_t              status;
    buf_wr_t              buf_wr;
    logic [DATA_W-1:0]    ram_q;

    logic                 s1_valid_reg;
    status_t              s1_status_reg;
    logic                 s1_rd_reg;
    result_t              s1_result;

    result_t              fifo_reg [RES_FIFO_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic                 push;
    logic                 pop;
    result_t              head;

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            download_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            download_mode_reg <= cfg_data;
        end
    end

    // input handshake: room for the in-flight item must remain in the queue
    assign in_stall = (count_reg == RES_CNT_W'(RES_FIFO_DEPTH))
                   || ((count_reg == RES_CNT_W'(RES_FIFO_DEPTH - 1)) && s1_valid_reg);
    assign accept   = in_valid && !in_stall;
    assign rd_en    = accept && (op_t'(op) == OP_READ);

    // framing state
    slfr_frame u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .op            (op),
        .rx_byte       (rx_byte),
        .download_mode (download_mode_reg),
        .status        (status),
        .buf_wr        (buf_wr)
    );

    // frame buffer
    slfr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .clk   (clk),
        .we    (buf_wr.we),
        .waddr (buf_wr.addr),
        .wdata (buf_wr.data),
        .re    (rd_en),
        .raddr (ADDR_W'(read_index)),
        .rdata (ram_q)
    );

    // result stage, aligned with the buffer read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status;
            s1_rd_reg     <= rd_en && (COUNT_W'(read_index) < DEPTH_LIMIT);
        end
    end

    assign s1_result.status    = s1_status_reg;
    assign s1_result.read_data = s1_rd_reg ? ram_q : '0;

    // result queue control
    assign push = s1_valid_reg;
    assign pop  = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == RES_PTR_W'(RES_FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + RES_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == RES_PTR_W'(RES_FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + RES_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + RES_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= s1_result;
        end
    end

    // output item
    assign head            = fifo_reg[rd_ptr_reg];
    assign out_valid       = (count_reg != '0);
    assign frame_complete  = head.status.frame_complete;
    assign cr_pending      = head.status.cr_pending;
    assign byte_count      = head.status.byte_count;
    assign expected_length = head.status.expected_length;
    assign frame_error     = head.status.frame_error;
    assign byte_dropped    = head.status.byte_dropped;
    assign read_data       = head.read_data;

endmodule
`default_nettype wire

// ===== rtl/slfr_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// slfr_checker
// Port-level checks on the serial line frame receiver's result items.
// ---------------------------------------------------------------------------
module slfr_checker
    import slfr_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic               frame_complete,
    input wire logic               cr_pending,
    input wire logic [COUNT_W-1:0] byte_count,
    input wire logic               frame_error,
    input wire logic               byte_dropped,
    input wire logic [DATA_W-1:0]  read_data
);

    // a dropped byte only happens while a frame is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_dropped |-> frame_complete)
        else $error("byte dropped without a pending frame");

    // a discard leaves an empty, incomplete frame with no pending CR
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_error |-> !frame_complete && !cr_pending && (byte_count == '0))
        else $error("discard left frame state behind");

    // one item cannot both discard and be dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(frame_error && byte_dropped))
        else $error("frame error and byte dropped together");

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(byte_count))
        else $error("stalled result item changed");

endmodule

bind serial_line_frame_receiver slfr_checker u_checker (.*);
`default_nettype wire

// ===== bench/serial_line_frame_receiver_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_line_frame_receiver_test
// Self-checking bench for the serial line frame receiver. An item-level model
// of the framing rules predicts the status of every item; results are checked
// field by field in order. Directed line, download and mode-switch cases come
// first, then buffer limits, output back-pressure and randomized frame
// traffic under several idle/stall mixes.
// ---------------------------------------------------------------------------
module serial_line_frame_receiver_test
    import slfr_pkg::*;
();

    localparam int CYCLE_LIMIT = 100000;
    localparam int DRAIN_CYCLES = 4;

    // clock and reset
    logic clk;
    logic rst_n = 1'b0;

    // block inputs, all known from time zero
    logic               cfg_we     = 1'b0;
    logic               cfg_data   = 1'b0;
    logic               in_valid   = 1'b0;
    logic [1:0]         op         = 2'd0;
    logic [DATA_W-1:0]  rx_byte    = '0;
    logic [INDEX_W-1:0] read_index = '0;
    logic               out_stall  = 1'b0;

    // block outputs
    logic               in_stall;
    logic               out_valid;
    logic               frame_complete;
    logic               cr_pending;
    logic [COUNT_W-1:0] byte_count;
    logic [COUNT_W-1:0] expected_length;
    logic               frame_error;
    logic               byte_dropped;
    logic [DATA_W-1:0]  read_data;

    // frame state model
    logic [DATA_W-1:0]  frame_copy [BUFFER_DEPTH];
    bit                 entry_written [BUFFER_DEPTH];
    logic [COUNT_W-1:0] model_count;
    logic [COUNT_W-1:0] model_length;
    bit                 model_cr;
    bit                 model_done;
    bit                 model_download;

    // status items awaiting their result
    result_t pending_status [$];

    // traffic shaping
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          stall_hold    = 0;

    // bookkeeping
    int fail_count         = 0;
    int item_count         = 0;
    int checked_count      = 0;
    int frames_done        = 0;
    int frames_discarded   = 0;
    int bytes_dropped      = 0;
    int mode_writes        = 0;
    int cycle_count        = 0;
    int input_stall_cycles = 0;

    serial_line_frame_receiver DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .rx_byte         (rx_byte),
        .read_index      (read_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame_complete  (frame_complete),
        .cr_pending      (cr_pending),
        .byte_count      (byte_count),
        .expected_length (expected_length),
        .frame_error     (frame_error),
        .byte_dropped    (byte_dropped),
        .read_data       (read_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // cycle count, input stall count and run timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (in_valid && in_stall)
            input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("** serial_line_frame_receiver: FAILED **");
            $finish;
        end
    end

    // receiver stall: long hold-off on request, else random
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            out_stall <= 1'b1;
            stall_hold = stall_hold - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // apply one item to the frame model and return the status it produces
    function automatic result_t advance_frame_state(op_t o, logic [DATA_W-1:0] b,
                                                    logic [INDEX_W-1:0] idx);
        result_t r;
        r = '0;
        case (o)
            OP_RX_BYTE:
            begin
                if (model_done)
                begin
                    r.status.byte_dropped = 1'b1;
                    bytes_dropped++;
                end
                else if (!model_download)
                begin
                    if (model_cr)
                    begin
                        model_cr = 1'b0;
                        if (b == ASCII_LF)
                        begin
                            model_done = 1'b1;
                            frames_done++;
                        end
                        else
                        begin
                            model_count = '0;
                            r.status.frame_error = 1'b1;
                            frames_discarded++;
                        end
                    end
                    else if (model_count < DEPTH_LIMIT)
                    begin
                        if (b == ASCII_CR)
                            model_cr = 1'b1;
                        else
                        begin
                            frame_copy[model_count[ADDR_W-1:0]] = b;
                            entry_written[model_count[ADDR_W-1:0]] = 1'b1;
                            model_count = model_count + 1'b1;
                        end
                    end
                    else
                    begin
                        // line buffer full
                        model_count = '0;
                        model_cr = 1'b0;
                        r.status.frame_error = 1'b1;
                        frames_discarded++;
                    end
                end
                else if (model_length == '0)
                    model_length = b;
                else
                begin
                    // bytes past the buffer are counted only
                    if (model_count < DEPTH_LIMIT)
                    begin
                        frame_copy[model_count[ADDR_W-1:0]] = b;
                        entry_written[model_count[ADDR_W-1:0]] = 1'b1;
                    end
                    model_count = model_count + 1'b1;
                    if (model_count == model_length)
                    begin
                        model_done = 1'b1;
                        frames_done++;
                    end
                end
            end
            OP_READ:
            begin
                if (int'(idx) < BUFFER_DEPTH)
                    r.read_data = frame_copy[idx];
            end
            OP_RELEASE:
            begin
                model_count = '0;
                model_length = '0;
                model_cr = 1'b0;
                model_done = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.status.frame_complete = model_done;
        r.status.cr_pending = model_cr;
        r.status.byte_count = model_count;
        r.status.expected_length = model_length;
        return r;
    endfunction

    task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    // result check against the oldest predicted status
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: result with no item outstanding, expected none, actual %0h",
                         $time, {frame_complete, cr_pending, byte_count, expected_length,
                                 frame_error, byte_dropped, read_data});
                fail_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                checked_count++;
                compare_field("frame_complete", 8'(want.status.frame_complete),
                              8'(frame_complete));
                compare_field("cr_pending", 8'(want.status.cr_pending), 8'(cr_pending));
                compare_field("byte_count", want.status.byte_count, byte_count);
                compare_field("expected_length", want.status.expected_length,
                              expected_length);
                compare_field("frame_error", 8'(want.status.frame_error), 8'(frame_error));
                compare_field("byte_dropped", 8'(want.status.byte_dropped),
                              8'(byte_dropped));
                compare_field("read_data", want.read_data, read_data);
            end
        end
    end

    // offer one item, with random idle cycles first, and predict its status
    task automatic send_item(op_t o, logic [DATA_W-1:0] b, logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        rx_byte    <= b;
        read_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_status.push_back(advance_frame_state(o, b, idx));
        item_count++;
    endtask

    task automatic send_byte(logic [DATA_W-1:0] b);
        send_item(OP_RX_BYTE, b, INDEX_W'($urandom_range(127)));
    endtask

    task automatic send_op(op_t o);
        send_item(o, DATA_W'($urandom_range(255)), INDEX_W'($urandom_range(127)));
    endtask

    task automatic read_entry(int unsigned idx);
        send_item(OP_READ, DATA_W'($urandom_range(255)), INDEX_W'(idx));
    endtask

    // read a random entry that holds a received byte, else ask for status
    task automatic read_stored_entry();
        int unsigned start;
        int unsigned k;
        start = $urandom_range(BUFFER_DEPTH - 1);
        for (k = 0; k < BUFFER_DEPTH; k++)
            if (entry_written[(start + k) % BUFFER_DEPTH])
                break;
        if (k == BUFFER_DEPTH)
            send_op(OP_STATUS);
        else
            read_entry((start + k) % BUFFER_DEPTH);
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_download_mode(bit download);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= download;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_download = download;
        mode_writes++;
    endtask

    function automatic logic [DATA_W-1:0] line_data_byte();
        logic [DATA_W-1:0] b;
        do
            b = DATA_W'($urandom_range(255));
        while (b == ASCII_CR);
        return b;
    endfunction

    // mostly short frames, a few near the top of the range
    function automatic int unsigned pick_frame_len(int unsigned low, int unsigned top);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 88)
            return $urandom_range(low, 20);
        else if (r < 96)
            return $urandom_range(21, 90);
        else
            return $urandom_range(top - 10, top);
    endfunction

    // stray bytes, reads of the held frame, then usually a release
    task automatic frame_epilogue();
        repeat ($urandom_range(2)) send_byte(DATA_W'($urandom_range(255)));
        repeat ($urandom_range(3)) read_stored_entry();
        if ($urandom_range(99) < 85)
            send_op(OP_RELEASE);
    endtask

    task automatic line_frame();
        int unsigned len;
        logic [DATA_W-1:0] b;
        len = pick_frame_len(0, 130);
        repeat (len) send_byte(line_data_byte());
        case ($urandom_range(9))
            7:
            begin
                // CR followed by something other than LF
                send_byte(ASCII_CR);
                do
                    b = DATA_W'($urandom_range(255));
                while (b == ASCII_LF);
                send_byte(b);
            end
            8:
            begin
                // no terminator, the next frame runs on
            end
            9:
                send_byte(DATA_W'($urandom_range(255)));
            default:
            begin
                send_byte(ASCII_CR);
                send_byte(ASCII_LF);
            end
        endcase
        frame_epilogue();
    endtask

    task automatic download_frame();
        int unsigned len;
        int unsigned sent;
        len = pick_frame_len(1, 255);
        if ($urandom_range(7) == 0)
            send_byte('0);
        send_byte(DATA_W'(len));
        // sometimes cut the frame short
        sent = ($urandom_range(9) == 0) ? $urandom_range(len - 1) : len;
        repeat (sent) send_byte(DATA_W'($urandom_range(255)));
        frame_epilogue();
    endtask

    task automatic noise_item();
        op_t o;
        o = op_t'($urandom_range(3));
        if (o == OP_READ)
            read_stored_entry();
        else
            send_item(o, DATA_W'($urandom_range(255)), INDEX_W'($urandom_range(127)));
    endtask

    // line framing: storage, CR without LF, completion, drop while pending
    task automatic test_line_basics();
        set_download_mode(1'b0);
        send_op(OP_STATUS);
        send_op(OP_RELEASE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(ASCII_CR);
        send_byte(8'h41);
        send_byte(8'h55);
        send_byte(ASCII_CR);
        send_byte(ASCII_LF);
        send_byte(8'h33);
        read_entry(0);
        read_entry(1);
        send_op(OP_RELEASE);
    endtask

    // download framing: zero length retried, CR as data, drop while pending
    task automatic test_download_basics();
        set_download_mode(1'b1);
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hAA);
        send_byte(ASCII_CR);
        send_byte(8'h01);
        read_entry(1);
        send_op(OP_STATUS);
        send_op(OP_RELEASE);
    endtask

    // pending CR survives a switch to download mode until release
    task automatic test_mode_switch();
        set_download_mode(1'b0);
        send_byte(ASCII_CR);
        set_download_mode(1'b1);
        send_byte(8'h03);
        send_byte(8'h10);
        send_op(OP_RELEASE);
    endtask

    // full line buffer, longest line frame, longest download frame
    task automatic test_buffer_limits();
        int k;
        set_download_mode(1'b0);
        repeat (BUFFER_DEPTH) send_byte(line_data_byte());
        send_byte(ASCII_CR);
        repeat (BUFFER_DEPTH) send_byte(line_data_byte());
        send_byte(line_data_byte());
        repeat (BUFFER_DEPTH - 1) send_byte(line_data_byte());
        send_byte(ASCII_CR);
        send_byte(ASCII_LF);
        read_entry(0);
        read_entry(BUFFER_DEPTH - 1);
        for (k = 0; k < INDEX_W; k++)
            read_entry(1 << k);
        send_op(OP_RELEASE);
        set_download_mode(1'b1);
        send_byte(8'hFF);
        repeat (255) send_byte(DATA_W'($urandom_range(255)));
        send_byte(DATA_W'($urandom_range(255)));
        repeat (6) read_stored_entry();
        send_op(OP_RELEASE);
    endtask

    // receiver holds off while items keep coming, so the block stalls its input
    task automatic test_output_backpressure();
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_download_mode(1'b1);
        stall_hold = 60;
        send_byte(8'd12);
        repeat (12) send_byte(DATA_W'($urandom_range(255)));
        repeat (4) read_stored_entry();
        send_op(OP_RELEASE);
    endtask

    // mostly well-formed frames with random content, some noise
    task automatic test_random_traffic(int quota, int unsigned send_pct,
                                       int unsigned recv_pct);
        int start_items;
        int unsigned pick;
        settle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_items = item_count;
        while (item_count - start_items < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                if (model_download)
                    set_download_mode(1'b0);
                line_frame();
            end
            else if (pick < 85)
            begin
                if (!model_download)
                    set_download_mode(1'b1);
                download_frame();
            end
            else
                repeat ($urandom_range(1, 4)) noise_item();
        end
    endtask

    initial
    begin
        model_count    = '0;
        model_length   = '0;
        model_cr       = 1'b0;
        model_done     = 1'b0;
        model_download = 1'b0;
        foreach (frame_copy[i])
        begin
            frame_copy[i] = '0;
            entry_written[i] = 1'b0;
        end

        // hold reset, then release it
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_line_basics();
        test_download_basics();
        test_mode_switch();
        test_buffer_limits();
        test_output_backpressure();
        test_random_traffic(300, 25, 60);
        test_random_traffic(300, 60, 25);
        test_random_traffic(300, 0, 0);
        settle();

        $display("run covered %0d items and %0d checked results, %0d mode writes",
                 item_count, checked_count, mode_writes);
        $display("frames: %0d completed, %0d discarded, %0d bytes dropped; %0d input stall cycles",
                 frames_done, frames_discarded, bytes_dropped, input_stall_cycles);
        if (fail_count == 0)
            $display("** serial_line_frame_receiver: PASSED **");
        else
            $display("** serial_line_frame_receiver: FAILED **");
        $finish;
    end

endmodule
